// ===== rtl/bitmap_page_frame_allocator_macros.svh =====
// Assertion macros shared by the page frame allocator RTL.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define BPFA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator check failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define BPFA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator check failed");

`endif

// ===== rtl/bpfa_pkg.sv =====
// Types, constants and codes shared by the page frame allocator.
`timescale 1ns / 1ps
package bpfa_pkg;
	localparam int PAGE_W     = 21;
	localparam int ADDR_W     = 32;
	localparam int CNT_W      = 8;
	localparam int FIRST_W    = 20;
	localparam int WORD_W     = 8;
	localparam int OFS_W      = 3;
	localparam int PAGE_SHIFT = 12;
	localparam int POP_W      = 4;

	localparam int NUM_BLOCKS_DEF = 32768;
	localparam int MAX_RUN_DEF    = 255;
	localparam logic [PAGE_W-1:0] TOTAL_RESET = 21'd32768;

	localparam logic [1:0] CMD_ALLOC     = 2'd0;
	localparam logic [1:0] CMD_FREE      = 2'd1;
	localparam logic [1:0] CMD_MARK_FREE = 2'd2;
	localparam logic [1:0] CMD_MARK_USED = 2'd3;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NO_SPACE = 2'd1;
	localparam logic [1:0] STAT_NULL     = 2'd2;
	localparam logic [1:0] STAT_RANGE    = 2'd3;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_RCNT_RD,
		S_RCNT_PR,
		S_SCAN_RD,
		S_SCAN_PR,
		S_APPLY_RD,
		S_APPLY_PR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [PAGE_W-1:0] base;
		logic [PAGE_W-1:0] lo;
		logic [PAGE_W-1:0] hi;
		logic              val;
		logic [CNT_W-1:0]  need;
		logic [CNT_W-1:0]  run;
	} word_ctl_t;

	typedef struct packed {
		logic [WORD_W-1:0] new_word;
		logic [POP_W-1:0]  flips;
		logic [POP_W-1:0]  ones;
		logic [POP_W-1:0]  zeros;
		logic [CNT_W-1:0]  run;
		logic              found;
		logic [PAGE_W-1:0] start;
	} word_res_t;
endpackage

// ===== rtl/bpfa_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module bpfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== rtl/bpfa_word_unit.sv =====
// Shared unit that counts, rewrites and run-scans one bitmap word.
`timescale 1ns / 1ps
module bpfa_word_unit (
	input  logic [bpfa_pkg::WORD_W-1:0] word,
	input  bpfa_pkg::word_ctl_t         ctl,
	output bpfa_pkg::word_res_t         res
);
	always_comb begin
		logic [bpfa_pkg::PAGE_W-1:0] pj;
		logic                        inr;
		res = '0;
		res.run = ctl.run;
		for (int j = 0; j < bpfa_pkg::WORD_W; j++) begin
			pj = ctl.base + bpfa_pkg::PAGE_W'(j);
			inr = (pj >= ctl.lo) && (pj < ctl.hi);
			res.new_word[j] = inr ? ctl.val : word[j];
			res.flips = res.flips + bpfa_pkg::POP_W'(inr && (word[j] != ctl.val));
			res.ones  = res.ones  + bpfa_pkg::POP_W'(inr && word[j]);
			res.zeros = res.zeros + bpfa_pkg::POP_W'(inr && !word[j]);
			// Run search walks the pages in order and stops at the first fit.
			if ((pj < ctl.hi) && !res.found) begin
				if (word[j]) begin
					res.run = '0;
				end else begin
					res.run = res.run + 1'b1;
					if (res.run == ctl.need) begin
						res.found = 1'b1;
						res.start = pj + 1'b1 - bpfa_pkg::PAGE_W'(ctl.need);
					end
				end
			end
		end
	end
endmodule

// ===== rtl/bitmap_page_frame_allocator.sv =====
// Top level of the first-fit bitmap page frame allocator.
//
// Each request on the in channel (valid/ready) carries a command: allocate a
// run of count pages, free count pages at a byte address, or mark a page range
// free or used. Every request yields one result on the out channel with the
// status, the allocated byte address and both page counters after the command.
// The bitmap sits in a RAM of 8-page words; a sequencer drives one shared word
// unit through it, handling each word in a read state and then a count or
// rewrite state. An allocation scans from page zero up to the word holding
// the end of the first fitting run, then rewrites the words of that run; free
// and mark touch the words of their range. Requests that fail early go
// straight to the result. After reset a clearing pass writes every word to
// used, one word per cycle, while no request is taken. A write of the page
// total through cfg_we starts a recount of the words below the limit before
// the next request is taken. The result sits in an output register: a stalled
// receiver holds it, and a new request may be taken meanwhile, waiting to
// deliver.
`timescale 1ns / 1ps
`include "bitmap_page_frame_allocator_macros.svh"
module bitmap_page_frame_allocator #(
	parameter int NUM_BLOCKS = bpfa_pkg::NUM_BLOCKS_DEF,
	parameter int MAX_RUN    = bpfa_pkg::MAX_RUN_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bpfa_pkg::PAGE_W-1:0]  cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   cmd,
	input  logic [bpfa_pkg::ADDR_W-1:0]  address,
	input  logic [bpfa_pkg::CNT_W-1:0]   count,
	input  logic [bpfa_pkg::FIRST_W-1:0] first_block,
	input  logic [bpfa_pkg::PAGE_W-1:0]  range_length,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   status,
	output logic [bpfa_pkg::ADDR_W-1:0]  base_address,
	output logic [bpfa_pkg::PAGE_W-1:0]  free_pages,
	output logic [bpfa_pkg::PAGE_W-1:0]  used_pages
);
	localparam int PW    = bpfa_pkg::PAGE_W;
	localparam int DEPTH = (NUM_BLOCKS + bpfa_pkg::WORD_W - 1) / bpfa_pkg::WORD_W;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [PW-1:0] NB = PW'(NUM_BLOCKS);
	localparam logic [PW-1:0] USED_RESET =
		(bpfa_pkg::TOTAL_RESET < NB) ? bpfa_pkg::TOTAL_RESET : NB;

	bpfa_pkg::state_t state_q, state_d;

	logic [PW-1:0]  total_q, free_q, used_q, pg_q, lo_q, hi_q;
	logic           pend_q, val_q;
	logic [AW-1:0]  init_q;
	logic [bpfa_pkg::CNT_W-1:0] need_q, run_q;
	logic [1:0]     stat_q;
	logic [bpfa_pkg::ADDR_W-1:0] base_q;
	logic           out_valid_q;
	logic [1:0]     status_q;
	logic [bpfa_pkg::ADDR_W-1:0] base_address_q;
	logic [PW-1:0]  free_pages_q, used_pages_q;

	logic [PW-1:0]  lim;
	logic           accept, deliver;
	logic [bpfa_pkg::CNT_W-1:0] n_acc;
	logic [PW:0]    end_raw;
	logic [PW-1:0]  lo_acc, hi_acc;
	logic           clip;
	logic           early_fail;
	logic [1:0]     early_stat;

	logic                         ram_we, ram_re;
	logic [AW-1:0]                ram_waddr, ram_raddr;
	logic [bpfa_pkg::WORD_W-1:0]  ram_wdata, ram_rdata;
	bpfa_pkg::word_ctl_t          ctl;
	bpfa_pkg::word_res_t          res;

	assign lim     = (total_q < NB) ? total_q : NB;
	assign accept  = in_valid && in_ready;
	assign deliver = (state_q == bpfa_pkg::S_DONE) && (!out_valid_q || out_ready);

	// Request decode: run length, range bounds clipped to the limit.
	always_comb begin
		n_acc = (count == '0) ? bpfa_pkg::CNT_W'(1) : count;
		if (cmd == bpfa_pkg::CMD_FREE) begin
			lo_acc  = PW'(address[bpfa_pkg::ADDR_W-1:bpfa_pkg::PAGE_SHIFT]);
			end_raw = (PW+1)'(lo_acc) + (PW+1)'(count);
		end else begin
			lo_acc  = PW'(first_block);
			end_raw = (PW+1)'(first_block) + (PW+1)'(range_length);
		end
		clip   = end_raw > (PW+1)'(lim);
		hi_acc = clip ? lim : end_raw[PW-1:0];
		early_fail = 1'b0;
		early_stat = bpfa_pkg::STAT_OK;
		priority if (cmd == bpfa_pkg::CMD_ALLOC) begin
			if (n_acc > bpfa_pkg::CNT_W'(MAX_RUN)) begin
				early_fail = 1'b1;
				early_stat = bpfa_pkg::STAT_RANGE;
			end else if (PW'(n_acc) > free_q) begin
				early_fail = 1'b1;
				early_stat = bpfa_pkg::STAT_NO_SPACE;
			end
		end else if ((cmd == bpfa_pkg::CMD_FREE) && (address == '0)) begin
			early_fail = 1'b1;
			early_stat = bpfa_pkg::STAT_NULL;
		end else begin
			early_fail = 1'b0;
		end
	end

	assign ctl.base = pg_q;
	assign ctl.lo   = lo_q;
	assign ctl.hi   = hi_q;
	assign ctl.val  = val_q;
	assign ctl.need = need_q;
	assign ctl.run  = run_q;

	bpfa_word_unit u_unit (
		.word(ram_rdata),
		.ctl (ctl),
		.res (res)
	);

	bpfa_ram #(
		.WIDTH(bpfa_pkg::WORD_W),
		.DEPTH(DEPTH)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bpfa_pkg::S_INIT: begin
				if (init_q == AW'(DEPTH - 1)) begin
					state_d = bpfa_pkg::S_IDLE;
				end
			end
			bpfa_pkg::S_IDLE: begin
				if (pend_q) begin
					state_d = bpfa_pkg::S_RCNT_RD;
				end else if (accept) begin
					if (early_fail) begin
						state_d = bpfa_pkg::S_DONE;
					end else if (cmd == bpfa_pkg::CMD_ALLOC) begin
						state_d = bpfa_pkg::S_SCAN_RD;
					end else begin
						state_d = bpfa_pkg::S_APPLY_RD;
					end
				end
			end
			bpfa_pkg::S_RCNT_RD: begin
				state_d = (pg_q >= hi_q) ? bpfa_pkg::S_IDLE : bpfa_pkg::S_RCNT_PR;
			end
			bpfa_pkg::S_RCNT_PR: begin
				state_d = bpfa_pkg::S_RCNT_RD;
			end
			bpfa_pkg::S_SCAN_RD: begin
				state_d = (pg_q >= hi_q) ? bpfa_pkg::S_DONE : bpfa_pkg::S_SCAN_PR;
			end
			bpfa_pkg::S_SCAN_PR: begin
				state_d = res.found ? bpfa_pkg::S_APPLY_RD : bpfa_pkg::S_SCAN_RD;
			end
			bpfa_pkg::S_APPLY_RD: begin
				state_d = (pg_q >= hi_q) ? bpfa_pkg::S_DONE : bpfa_pkg::S_APPLY_PR;
			end
			bpfa_pkg::S_APPLY_PR: begin
				state_d = bpfa_pkg::S_APPLY_RD;
			end
			bpfa_pkg::S_DONE: begin
				if (deliver) begin
					state_d = bpfa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bpfa_pkg::S_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer: handshake and RAM control.
	always_comb begin
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = pg_q[bpfa_pkg::OFS_W +: AW];
		ram_raddr = pg_q[bpfa_pkg::OFS_W +: AW];
		ram_wdata = res.new_word;
		unique case (state_q)
			bpfa_pkg::S_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = init_q;
				ram_wdata = '1;
			end
			bpfa_pkg::S_IDLE: begin
				in_ready = !pend_q;
			end
			bpfa_pkg::S_RCNT_RD, bpfa_pkg::S_SCAN_RD, bpfa_pkg::S_APPLY_RD: begin
				ram_re = pg_q < hi_q;
			end
			bpfa_pkg::S_APPLY_PR: begin
				ram_we = 1'b1;
			end
			bpfa_pkg::S_RCNT_PR, bpfa_pkg::S_SCAN_PR, bpfa_pkg::S_DONE: begin
				ram_re = 1'b0;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bpfa_pkg::S_INIT;
			init_q      <= '0;
			total_q     <= bpfa_pkg::TOTAL_RESET;
			free_q      <= '0;
			used_q      <= USED_RESET;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == bpfa_pkg::S_INIT) begin
				init_q <= init_q + 1'b1;
			end
			// A write that lands while a recount starts keeps the flag set,
			// so the counters are counted again over the newest limit.
			if (cfg_we) begin
				total_q <= cfg_wdata;
				pend_q  <= 1'b1;
			end else if (state_q == bpfa_pkg::S_IDLE) begin
				pend_q <= 1'b0;
			end
			if (deliver) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				bpfa_pkg::S_IDLE: begin
					if (pend_q) begin
						// Recount both counters over the new limit.
						free_q <= '0;
						used_q <= '0;
					end
				end
				bpfa_pkg::S_RCNT_PR: begin
					used_q <= used_q + PW'(res.ones);
					free_q <= free_q + PW'(res.zeros);
				end
				bpfa_pkg::S_APPLY_PR: begin
					if (val_q) begin
						used_q <= used_q + PW'(res.flips);
						free_q <= free_q - PW'(res.flips);
					end else begin
						used_q <= used_q - PW'(res.flips);
						free_q <= free_q + PW'(res.flips);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers of the sequencer.
	always_ff @(posedge clk) begin
		unique case (state_q)
			bpfa_pkg::S_IDLE: begin
				if (pend_q) begin
					pg_q <= '0;
					lo_q <= '0;
					hi_q <= lim;
				end else if (accept) begin
					need_q <= n_acc;
					run_q  <= '0;
					base_q <= '0;
					val_q  <= (cmd == bpfa_pkg::CMD_MARK_USED);
					if (early_fail) begin
						stat_q <= early_stat;
					end else if (cmd == bpfa_pkg::CMD_ALLOC) begin
						stat_q <= bpfa_pkg::STAT_OK;
						pg_q   <= '0;
						lo_q   <= '0;
						hi_q   <= lim;
					end else begin
						stat_q <= clip ? bpfa_pkg::STAT_RANGE : bpfa_pkg::STAT_OK;
						pg_q   <= {lo_acc[PW-1:bpfa_pkg::OFS_W], bpfa_pkg::OFS_W'(0)};
						lo_q   <= lo_acc;
						hi_q   <= hi_acc;
					end
				end
			end
			bpfa_pkg::S_SCAN_RD: begin
				if (pg_q >= hi_q) begin
					stat_q <= bpfa_pkg::STAT_NO_SPACE;
				end
			end
			bpfa_pkg::S_SCAN_PR: begin
				if (res.found) begin
					// Switch to marking the run used.
					lo_q   <= res.start;
					hi_q   <= res.start + PW'(need_q);
					val_q  <= 1'b1;
					pg_q   <= {res.start[PW-1:bpfa_pkg::OFS_W], bpfa_pkg::OFS_W'(0)};
					base_q <= bpfa_pkg::ADDR_W'(res.start) << bpfa_pkg::PAGE_SHIFT;
				end else begin
					run_q <= res.run;
					pg_q  <= pg_q + PW'(bpfa_pkg::WORD_W);
				end
			end
			bpfa_pkg::S_RCNT_PR, bpfa_pkg::S_APPLY_PR: begin
				pg_q <= pg_q + PW'(bpfa_pkg::WORD_W);
			end
			default: begin
			end
		endcase
		if (deliver) begin
			status_q       <= stat_q;
			base_address_q <= base_q;
			free_pages_q   <= free_q;
			used_pages_q   <= used_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign base_address = base_address_q;
	assign free_pages   = free_pages_q;
	assign used_pages   = used_pages_q;

	`BPFA_ASSERT_IMP(a_counters_sum, (state_q == bpfa_pkg::S_IDLE) && !pend_q,
		(PW+1)'(free_q) + (PW+1)'(used_q) == (PW+1)'(lim))
	`BPFA_ASSERT_NXT(a_accept_leaves_idle, accept, state_q != bpfa_pkg::S_IDLE)
	`BPFA_ASSERT_IMP(a_write_only_init_apply, ram_we,
		(state_q == bpfa_pkg::S_INIT) || (state_q == bpfa_pkg::S_APPLY_PR))
endmodule

// ===== dv/bitmap_page_frame_allocator_test.sv =====
// Self-checking testbench for the first-fit bitmap page frame allocator.
`timescale 1ns / 1ps
module bitmap_page_frame_allocator_test;
	localparam int PAGES   = bpfa_pkg::NUM_BLOCKS_DEF;
	localparam int RUN_MAX = bpfa_pkg::MAX_RUN_DEF;

	typedef struct {
		logic [1:0]                   cmd;
		logic [bpfa_pkg::ADDR_W-1:0]  address;
		logic [bpfa_pkg::CNT_W-1:0]   count;
		logic [bpfa_pkg::FIRST_W-1:0] first_block;
		logic [bpfa_pkg::PAGE_W-1:0]  range_length;
	} page_request_t;

	typedef struct {
		logic [1:0]                  status;
		logic [bpfa_pkg::ADDR_W-1:0] base_address;
		logic [bpfa_pkg::PAGE_W-1:0] free_pages;
		logic [bpfa_pkg::PAGE_W-1:0] used_pages;
	} page_result_t;

	typedef struct {
		int unsigned start;
		int unsigned pages;
	} page_run_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [bpfa_pkg::PAGE_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] cmd = bpfa_pkg::CMD_ALLOC;
	logic [bpfa_pkg::ADDR_W-1:0] address = '0;
	logic [bpfa_pkg::CNT_W-1:0] count = '0;
	logic [bpfa_pkg::FIRST_W-1:0] first_block = '0;
	logic [bpfa_pkg::PAGE_W-1:0] range_length = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic [bpfa_pkg::ADDR_W-1:0] base_address;
	logic [bpfa_pkg::PAGE_W-1:0] free_pages;
	logic [bpfa_pkg::PAGE_W-1:0] used_pages;

	bitmap_page_frame_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .address(address), .count(count),
		.first_block(first_block), .range_length(range_length),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .base_address(base_address),
		.free_pages(free_pages), .used_pages(used_pages)
	);

	always #10 clk = ~clk;

	// Shadow of the allocator: one used bit per page, both counters and the
	// configured page total.
	bit          page_used [PAGES];
	int unsigned free_count;
	int unsigned used_count;
	int unsigned total_pages;

	page_request_t pending_requests[$];
	page_result_t  expected_results[$];
	page_run_t     allocated_runs[$];

	int  mismatches = 0;
	bit  calm = 1'b0;
	int  send_gap = 0;
	int  recv_stall = 0;
	bit  drain_hold = 1'b0;

	function automatic int unsigned page_limit();
		return (total_pages < PAGES) ? total_pages : PAGES;
	endfunction

	// Counters move only when a bit really flips.
	function automatic void set_page(int unsigned p, bit used);
		if (page_used[p] == used)
			return;
		page_used[p] = used;
		if (used) begin
			used_count++;
			free_count--;
		end else begin
			free_count++;
			used_count--;
		end
	endfunction

	function automatic void recount_pages();
		free_count = 0;
		used_count = 0;
		for (int unsigned p = 0; p < page_limit(); p++) begin
			if (page_used[p])
				used_count++;
			else
				free_count++;
		end
	endfunction

	function automatic page_result_t predict_request(page_request_t r);
		page_result_t res;
		int unsigned lim;
		int unsigned n;
		int unsigned run;
		int unsigned start;
		int unsigned stop;
		bit found;
		lim = page_limit();
		res.status = bpfa_pkg::STAT_OK;
		res.base_address = '0;
		case (r.cmd)
			bpfa_pkg::CMD_ALLOC: begin
				n = (r.count == 0) ? 1 : r.count;
				if (n > RUN_MAX) begin
					res.status = bpfa_pkg::STAT_RANGE;
				end else if (n > free_count) begin
					res.status = bpfa_pkg::STAT_NO_SPACE;
				end else begin
					run = 0;
					found = 1'b0;
					start = 0;
					for (int unsigned p = 0; p < lim && !found; p++) begin
						if (page_used[p]) begin
							run = 0;
						end else begin
							run++;
							if (run == n) begin
								start = p + 1 - n;
								found = 1'b1;
							end
						end
					end
					if (found) begin
						for (int unsigned p = start; p < start + n; p++)
							set_page(p, 1'b1);
						res.base_address = start << bpfa_pkg::PAGE_SHIFT;
						allocated_runs.push_back('{start, n});
					end else begin
						res.status = bpfa_pkg::STAT_NO_SPACE;
					end
				end
			end
			bpfa_pkg::CMD_FREE: begin
				if (r.address == 0) begin
					res.status = bpfa_pkg::STAT_NULL;
				end else begin
					start = r.address >> bpfa_pkg::PAGE_SHIFT;
					stop = start + r.count;
					if (stop > lim) begin
						res.status = bpfa_pkg::STAT_RANGE;
						stop = lim;
					end
					for (int unsigned p = start; p < stop; p++)
						set_page(p, 1'b0);
				end
			end
			default: begin
				start = r.first_block;
				stop = start + r.range_length;
				if (stop > lim) begin
					res.status = bpfa_pkg::STAT_RANGE;
					stop = lim;
				end
				for (int unsigned p = start; p < stop; p++)
					set_page(p, r.cmd == bpfa_pkg::CMD_MARK_USED);
			end
		endcase
		res.free_pages = bpfa_pkg::PAGE_W'(free_count);
		res.used_pages = bpfa_pkg::PAGE_W'(used_count);
		return res;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(40, 150);
	endfunction

	function automatic page_request_t make_request(logic [1:0] c, logic [31:0] a,
			logic [7:0] n, logic [19:0] f, logic [20:0] len);
		page_request_t r;
		r.cmd = c;
		r.address = a;
		r.count = n;
		r.first_block = f;
		r.range_length = len;
		return r;
	endfunction

	// Random request shaped for the current limit. Wide ranges are allowed
	// only when the limit keeps the block's walk through the bitmap short.
	function automatic page_request_t random_request(bit wide);
		page_request_t r;
		int unsigned lim;
		int unsigned k;
		int pick;
		lim = page_limit();
		r = make_request(2'($urandom_range(0, 3)), $urandom, 8'($urandom),
			20'($urandom), 21'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			r.cmd = bpfa_pkg::CMD_ALLOC;
			r.count = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 12))
				: 8'($urandom_range(0, 255));
		end else if (pick < 72) begin
			r.cmd = bpfa_pkg::CMD_FREE;
			if (allocated_runs.size() != 0 && $urandom_range(0, 9) < 6) begin
				k = $urandom_range(0, allocated_runs.size() - 1);
				r.address = (allocated_runs[k].start << bpfa_pkg::PAGE_SHIFT) |
					$urandom_range(0, 4095);
				r.count = 8'(allocated_runs[k].pages);
				allocated_runs.delete(k);
			end else if ($urandom_range(0, 19) == 0) begin
				r.address = '0;
			end else if ($urandom_range(0, 9) != 0 || !wide) begin
				r.address = ($urandom_range(0, lim + 4) << bpfa_pkg::PAGE_SHIFT) |
					$urandom_range(0, 4095);
				r.count = 8'($urandom_range(0, 16));
			end
		end else begin
			r.cmd = ($urandom_range(0, 1) != 0) ? bpfa_pkg::CMD_MARK_FREE
				: bpfa_pkg::CMD_MARK_USED;
			if (!wide || $urandom_range(0, 9) != 0) begin
				r.first_block = 20'($urandom_range(0, lim));
				r.range_length = 21'($urandom_range(0, (lim < 64) ? lim : lim / 4));
			end
		end
		return r;
	endfunction

	// Request driver: presents the head of the pending queue and predicts
	// each request at the edge where it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(predict_request(pending_requests.pop_front()));
				send_gap = calm ? 0 : pick_gap();
				if (!calm && $urandom_range(0, 199) == 0)
					drain_hold = 1'b1;
			end
			if (drain_hold && expected_results.size() == 0)
				drain_hold = 1'b0;
			if (in_valid && !in_ready) begin
				// Hold the request until it is taken.
			end else if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (drain_hold || pending_requests.size() == 0) begin
				in_valid <= 1'b0;
			end else begin
				in_valid <= 1'b1;
				cmd <= pending_requests[0].cmd;
				address <= pending_requests[0].address;
				count <= pending_requests[0].count;
				first_block <= pending_requests[0].first_block;
				range_length <= pending_requests[0].range_length;
			end
		end
	end

	// Result monitor: compares every delivered result with the oldest
	// prediction and stalls the out channel at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Result with no request waiting: status %0d base %h",
							status, base_address);
				end else begin
					page_result_t e;
					e = expected_results.pop_front();
					if (status !== e.status || base_address !== e.base_address ||
							free_pages !== e.free_pages || used_pages !== e.used_pages) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch: expected status %0d base %h free %0d used %0d, %s",
								e.status, e.base_address, e.free_pages, e.used_pages,
								$sformatf("got status %0d base %h free %0d used %0d",
									status, base_address, free_pages, used_pages));
					end
				end
			end
			if (recv_stall > 0) begin
				recv_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!calm)
					recv_stall = pick_gap();
			end
		end
	end

	task automatic queue_request(page_request_t r);
		while (pending_requests.size() >= 4)
			@(posedge clk);
		pending_requests.push_back(r);
	endtask

	// Waits until the block has answered everything and is idle, then
	// writes the page total. The shadow recounts at the same moment.
	task automatic write_total(logic [bpfa_pkg::PAGE_W-1:0] v);
		do
			@(posedge clk);
		while (pending_requests.size() != 0 || expected_results.size() != 0 || in_valid);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		total_pages = v;
		recount_pages();
		allocated_runs.delete();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int unsigned totals[8];
		for (int p = 0; p < PAGES; p++)
			page_used[p] = 1'b1;
		total_pages = 32768;
		recount_pages();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests at the reset limit, starting with every page used.
		queue_request(make_request(bpfa_pkg::CMD_ALLOC, 0, 1, 0, 0));
		queue_request(make_request(bpfa_pkg::CMD_FREE, 0, 5, 0, 0));
		queue_request(make_request(bpfa_pkg::CMD_MARK_FREE, 0, 0, 0, 64));
		queue_request(make_request(bpfa_pkg::CMD_ALLOC, 0, 0, 0, 0));
		queue_request(make_request(bpfa_pkg::CMD_ALLOC, 0, 255, 0, 0));
		queue_request(make_request(bpfa_pkg::CMD_MARK_FREE, 0, 0, 20'hFFFFF, 21'h100000));
		queue_request(make_request(bpfa_pkg::CMD_MARK_USED, 0, 0, 0, 0));
		queue_request(make_request(bpfa_pkg::CMD_FREE, 32'hFFFFFFFF, 8'hFF, 0, 0));
		queue_request(make_request(bpfa_pkg::CMD_FREE, 32'h0000_1FFF, 3, 0, 0));
		queue_request(make_request(bpfa_pkg::CMD_FREE, 32'h0000_1000, 3, 0, 0));
		queue_request(make_request(bpfa_pkg::CMD_FREE, 32'h0000_1000, 0, 0, 0));
		queue_request(make_request(bpfa_pkg::CMD_MARK_FREE, 0, 0, 32760, 100));
		queue_request(make_request(bpfa_pkg::CMD_ALLOC, 0, 8, 0, 0));
		queue_request(make_request(bpfa_pkg::CMD_MARK_USED, 0, 0, 0, 21'h100000));
		queue_request(make_request(bpfa_pkg::CMD_ALLOC, 0, 1, 0, 0));
		queue_request(make_request(bpfa_pkg::CMD_MARK_FREE, 0, 0, 100, 255));
		queue_request(make_request(bpfa_pkg::CMD_MARK_USED, 0, 0, 150, 1));
		// Needs more pages than the free stretch below page 150 holds.
		queue_request(make_request(bpfa_pkg::CMD_ALLOC, 0, 200, 0, 0));
		queue_request(make_request(bpfa_pkg::CMD_ALLOC, 0, 104, 0, 0));
		queue_request(make_request(bpfa_pkg::CMD_MARK_USED, 0, 0, 40, 10));
		for (int i = 0; i < 40; i++)
			queue_request(random_request(1'b0));

		// Several limits, the smallest and the largest among them.
		totals = '{1, 21'h100000, 8, 37, 200, 1024, 513, 64};
		for (int ph = 0; ph < 8; ph++) begin
			write_total(bpfa_pkg::PAGE_W'(totals[ph]));
			calm = (ph % 3 == 1);
			queue_request(make_request(bpfa_pkg::CMD_MARK_FREE, 0, 0, 0,
				bpfa_pkg::PAGE_W'(page_limit())));
			for (int i = 0; i < ((page_limit() > 2048) ? 40 : 260); i++)
				queue_request(random_request(page_limit() <= 2048));
		end
		calm = 1'b0;

		do
			@(posedge clk);
		while (pending_requests.size() != 0 || expected_results.size() != 0 || in_valid);
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Safety net against a hung handshake.
	initial begin
		#1_000_000_000;
		$display("Verification failed");
		$finish;
	end
endmodule
